[rtl/u8d_pkg.sv]
// Shared types and constants for the UTF-8 decoder with UTF-16 truncation.
// Holds the work descriptor passed from the front end to the result generator.
// No dependencies.
package u8d_pkg;

    localparam logic [20:0] REPL_CP     = 21'h00FFFD;
    localparam logic [20:0] BMP_MAX     = 21'h00FFFF;
    localparam logic [15:0] LIMIT_RESET = 16'd256;

    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_VAL   = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_VAL  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_VAL  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_VAL  = 8'hF0;

    localparam logic [2:0] SEQ_IDLE = 3'd0;
    localparam logic [2:0] SEQ_LEN2 = 3'd2;
    localparam logic [2:0] SEQ_LEN3 = 3'd3;
    localparam logic [2:0] SEQ_LEN4 = 3'd4;

    localparam int OPQ_AW    = 1;
    localparam int OPQ_DEPTH = 1 << OPQ_AW;

    // Results of one item in order: pre replacements, main code,
    // post replacements, end marker.
    typedef struct packed {
        logic [1:0]  pre;
        logic        main_vld;
        logic [20:0] main_cp;
        logic [2:0]  main_nb;
        logic [1:0]  post;
        logic        marker;
        logic        last;
    } u8d_op_t;

endpackage

[rtl/u8d_front.sv]
// Front end: accepts bytes, tracks the open UTF-8 sequence, classifies each
// byte into a work descriptor for the result generator. Depends on u8d_pkg.
module u8d_front
    import u8d_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  logic [7:0] in_byte,
    input  logic     in_last,
    input  logic     q_full,
    output logic     q_wr,
    output u8d_op_t  q_op
);

    logic [7:0] pend_reg [3];
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic [2:0] exp_reg;
    logic [2:0] exp_next;

    logic       pend_we;
    logic [1:0] pend_idx;
    logic       is_cont;
    logic       zero_end;
    logic       has_work;
    logic       accept;
    u8d_op_t    op;

    always_comb
    begin
        is_cont  = (in_byte & CONT_MASK) == CONT_VAL;
        op       = '0;
        cnt_next = cnt_reg;
        exp_next = exp_reg;
        pend_we  = 1'b0;
        pend_idx = cnt_reg;
        zero_end = 1'b0;
        if (cnt_reg != 2'd0 && is_cont)
        begin
            if ({1'b0, cnt_reg} + 3'd1 == exp_reg)
            begin
                op.main_vld = 1'b1;
                op.main_nb  = exp_reg;
                case (exp_reg)
                    SEQ_LEN2: op.main_cp = {10'd0, pend_reg[0][4:0], in_byte[5:0]};
                    SEQ_LEN3: op.main_cp = {5'd0, pend_reg[0][3:0], pend_reg[1][5:0],
                                            in_byte[5:0]};
                    default:  op.main_cp = {pend_reg[0][2:0], pend_reg[1][5:0],
                                            pend_reg[2][5:0], in_byte[5:0]};
                endcase
                cnt_next = 2'd0;
                exp_next = SEQ_IDLE;
            end
            else
            begin
                pend_we  = 1'b1;
                cnt_next = cnt_reg + 2'd1;
                if (in_last)
                    op.post = cnt_reg + 2'd1;
            end
        end
        else
        begin
            op.pre   = cnt_reg;
            cnt_next = 2'd0;
            exp_next = SEQ_IDLE;
            pend_idx = 2'd0;
            if (in_byte == 8'd0)
                zero_end = 1'b1;
            else if (!in_byte[7])
            begin
                op.main_vld = 1'b1;
                op.main_cp  = {13'd0, in_byte};
                op.main_nb  = 3'd1;
            end
            else if ((in_byte & LEAD2_MASK) == LEAD2_VAL ||
                     (in_byte & LEAD3_MASK) == LEAD3_VAL ||
                     (in_byte & LEAD4_MASK) == LEAD4_VAL)
            begin
                pend_we  = 1'b1;
                cnt_next = 2'd1;
                if ((in_byte & LEAD2_MASK) == LEAD2_VAL)
                    exp_next = SEQ_LEN2;
                else if ((in_byte & LEAD3_MASK) == LEAD3_VAL)
                    exp_next = SEQ_LEN3;
                else
                    exp_next = SEQ_LEN4;
                if (in_last)
                    op.post = 2'd1;
            end
            else
            begin
                op.main_vld = 1'b1;
                op.main_cp  = REPL_CP;
                op.main_nb  = 3'd1;
            end
        end
        op.last   = in_last || zero_end;
        op.marker = zero_end ||
                    (in_last && op.pre == 2'd0 && !op.main_vld && op.post == 2'd0);
        if (op.last)
        begin
            cnt_next = 2'd0;
            exp_next = SEQ_IDLE;
        end
        has_work = op.pre != 2'd0 || op.main_vld || op.post != 2'd0 || op.marker;
    end

    assign accept = push && !q_full;
    assign full   = q_full;
    assign q_wr   = accept && has_work;
    assign q_op   = op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            exp_reg <= SEQ_IDLE;
        end
        else if (accept)
        begin
            cnt_reg <= cnt_next;
            exp_reg <= exp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && pend_we)
            pend_reg[pend_idx] <= in_byte;
    end

    a_open_seq_len: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd0 |-> ({1'b0, cnt_reg} < exp_reg &&
            (exp_reg == SEQ_LEN2 || exp_reg == SEQ_LEN3 || exp_reg == SEQ_LEN4)))
        else $error("open sequence count out of range");

    a_idle_no_len: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd0 |-> exp_reg == SEQ_IDLE)
        else $error("sequence length set with nothing buffered");

endmodule

[rtl/u8d_opq.sv]
// Short queue of work descriptors between front end and result generator.
// Depends on u8d_pkg.
module u8d_opq
    import u8d_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr,
    input  u8d_op_t wdata,
    input  logic    rd,
    output u8d_op_t rdata,
    output logic    full,
    output logic    empty
);

    u8d_op_t           mem_reg [OPQ_DEPTH];
    logic [OPQ_AW-1:0] wr_ptr_reg;
    logic [OPQ_AW-1:0] rd_ptr_reg;
    logic [OPQ_AW:0]   count_reg;
    logic              do_wr;
    logic              do_rd;

    assign full  = count_reg == (OPQ_AW + 1)'(OPQ_DEPTH);
    assign empty = count_reg == '0;
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

[rtl/u8d_back.sv]
// Result generator: expands work descriptors into one result per cycle unless
// pop low stalls; keeps the running UTF-16 and byte counts. Depends on u8d_pkg.
module u8d_back
    import u8d_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] unit_limit,
    input  logic        q_empty,
    input  u8d_op_t     q_op,
    output logic        q_rd,
    output logic        empty,
    input  logic        pop,
    output logic [20:0] code_point,
    output logic        has_code,
    output logic [15:0] utf16_units,
    output logic        fits,
    output logic [15:0] kept_bytes,
    output logic        out_last
);

    localparam int SUM_W = (COUNT_WIDTH + 1 > 17) ? COUNT_WIDTH + 1 : 17;

    u8d_op_t                cur_reg;
    u8d_op_t                cur_next;
    logic                   cur_vld_reg;
    logic [COUNT_WIDTH-1:0] units_reg;
    logic [COUNT_WIDTH-1:0] bytes_reg;
    logic [COUNT_WIDTH-1:0] good_reg;
    logic                   ovf_reg;
    logic [COUNT_WIDTH-1:0] units_next;
    logic [COUNT_WIDTH-1:0] bytes_next;
    logic [COUNT_WIDTH-1:0] good_next;
    logic                   ovf_next;

    logic                   ovld_reg;
    logic [20:0]            cp_reg;
    logic                   has_reg;
    logic [15:0]            u16_reg;
    logic                   fits_reg;
    logic [15:0]            kept_reg;
    logic                   last_reg;

    logic                   out_ready;
    logic                   emit;
    logic                   finishing;
    logic                   e_code;
    logic [20:0]            e_cp;
    logic [2:0]             e_nb;
    logic [1:0]             inc;
    logic [SUM_W-1:0]       u_sum;
    logic [SUM_W-1:0]       b_sum;
    logic [COUNT_WIDTH-1:0] u_sat;
    logic [COUNT_WIDTH-1:0] b_sat;
    logic                   fit_now;

    function automatic logic [15:0] sat16(input logic [COUNT_WIDTH-1:0] v);
        logic [SUM_W-1:0] ext;
        ext = SUM_W'(v);
        return (|ext[SUM_W-1:16]) ? 16'hFFFF : ext[15:0];
    endfunction

    always_comb
    begin
        cur_next = cur_reg;
        e_code   = 1'b1;
        e_cp     = REPL_CP;
        e_nb     = 3'd1;
        if (cur_reg.pre != 2'd0)
            cur_next.pre = cur_reg.pre - 2'd1;
        else if (cur_reg.main_vld)
        begin
            e_cp              = cur_reg.main_cp;
            e_nb              = cur_reg.main_nb;
            cur_next.main_vld = 1'b0;
        end
        else if (cur_reg.post != 2'd0)
            cur_next.post = cur_reg.post - 2'd1;
        else
        begin
            e_code          = 1'b0;
            e_cp            = '0;
            e_nb            = 3'd0;
            cur_next.marker = 1'b0;
        end
        finishing = cur_next.pre == 2'd0 && !cur_next.main_vld &&
                    cur_next.post == 2'd0 && !cur_next.marker;

        inc     = (e_cp <= BMP_MAX) ? 2'd1 : 2'd2;
        u_sum   = SUM_W'(units_reg) + SUM_W'(inc);
        b_sum   = SUM_W'(bytes_reg) + SUM_W'(e_nb);
        u_sat   = (|u_sum[SUM_W-1:COUNT_WIDTH]) ? '1 : u_sum[COUNT_WIDTH-1:0];
        b_sat   = (|b_sum[SUM_W-1:COUNT_WIDTH]) ? '1 : b_sum[COUNT_WIDTH-1:0];
        fit_now = !ovf_reg && (u_sum <= SUM_W'(unit_limit));

        units_next = units_reg;
        bytes_next = bytes_reg;
        good_next  = good_reg;
        ovf_next   = ovf_reg;
        if (e_code)
        begin
            units_next = u_sat;
            bytes_next = b_sat;
            good_next  = fit_now ? b_sat : good_reg;
            ovf_next   = !fit_now;
        end
    end

    assign out_ready = !ovld_reg || pop;
    assign emit      = cur_vld_reg && out_ready;
    assign q_rd      = !q_empty && (!cur_vld_reg || (emit && finishing));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_vld_reg <= 1'b0;
            ovld_reg    <= 1'b0;
            units_reg   <= '0;
            bytes_reg   <= '0;
            good_reg    <= '0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            if (q_rd)
                cur_vld_reg <= 1'b1;
            else if (emit && finishing)
                cur_vld_reg <= 1'b0;

            if (emit)
                ovld_reg <= 1'b1;
            else if (pop)
                ovld_reg <= 1'b0;

            if (emit)
            begin
                if (finishing && cur_reg.last)
                begin
                    units_reg <= '0;
                    bytes_reg <= '0;
                    good_reg  <= '0;
                    ovf_reg   <= 1'b0;
                end
                else
                begin
                    units_reg <= units_next;
                    bytes_reg <= bytes_next;
                    good_reg  <= good_next;
                    ovf_reg   <= ovf_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_rd)
            cur_reg <= q_op;
        else if (emit)
            cur_reg <= cur_next;

        if (emit)
        begin
            cp_reg   <= e_cp;
            has_reg  <= e_code;
            u16_reg  <= sat16(units_next);
            fits_reg <= !ovf_next;
            kept_reg <= sat16(good_next);
            last_reg <= finishing && cur_reg.last;
        end
    end

    assign empty       = !ovld_reg;
    assign code_point  = cp_reg;
    assign has_code    = has_reg;
    assign utf16_units = u16_reg;
    assign fits        = fits_reg;
    assign kept_bytes  = kept_reg;
    assign out_last    = last_reg;

    a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        ovld_reg && !has_reg |-> last_reg && cp_reg == '0)
        else $error("end marker not final or carries a code");

    a_kept_within_pos: assert property (@(posedge clk) disable iff (!rst_n)
        good_reg <= bytes_reg)
        else $error("kept prefix beyond byte position");

    a_units_within_pos: assert property (@(posedge clk) disable iff (!rst_n)
        units_reg <= bytes_reg)
        else $error("UTF-16 length exceeds byte count");

endmodule

[rtl/utf8_decode_utf16_truncate_top.sv]
// Top level of the UTF-8 decoder with UTF-16 length truncation.
// Instantiates u8d_front, u8d_opq and u8d_back; depends on u8d_pkg.
//
//   channel   handshake              payload
//   input     push / full            in_byte, in_last
//   result    pop / empty            code_point, has_code, utf16_units, fits,
//                                    kept_bytes, out_last
//   config    cfg_valid / cfg_ready  cfg_data (unit_limit)
//
// One byte per cycle while each byte yields at most one result and pop is not
// held low; a byte with more results holds the result generator, one result per cycle.
// A byte's descriptor goes through the work queue and the current register to the output.
// full rises while the two-entry work queue is full; pop low holds the result.
// Reset clears all sequence and count state and sets unit_limit to 256.
module utf8_decode_utf16_truncate_top
    import u8d_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        empty,
    input  logic        pop,
    output logic [20:0] code_point,
    output logic        has_code,
    output logic [15:0] utf16_units,
    output logic        fits,
    output logic [15:0] kept_bytes,
    output logic        out_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic [15:0] limit_reg;
    logic        q_wr;
    logic        q_rd;
    logic        q_full;
    logic        q_empty;
    u8d_op_t     q_wdata;
    u8d_op_t     q_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (cfg_valid && cfg_ready)
            limit_reg <= cfg_data;
    end

    u8d_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_byte (in_byte),
        .in_last (in_last),
        .q_full  (q_full),
        .q_wr    (q_wr),
        .q_op    (q_wdata)
    );

    u8d_opq u_opq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .wdata (q_wdata),
        .rd    (q_rd),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    u8d_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .unit_limit  (limit_reg),
        .q_empty     (q_empty),
        .q_op        (q_rdata),
        .q_rd        (q_rd),
        .empty       (empty),
        .pop         (pop),
        .code_point  (code_point),
        .has_code    (has_code),
        .utf16_units (utf16_units),
        .fits        (fits),
        .kept_bytes  (kept_bytes),
        .out_last    (out_last)
    );

endmodule
